// ===== rtl/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros for the rotation matrix to quaternion block.
// Used by the RTL files that carry assertions; depends on nothing.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTH
`define RMQ_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RMQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RMQ_ASSERT_IMPL(label, clk, rst, a, c)
`define RMQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int DW = 16;
  // Square root radicand: t < 2^18, shifted by FRAC_BITS.
  localparam int RAD_W = 34;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NCELL = ROOT_W;
  localparam int DET_W = 52;
  localparam logic [0:0] CFG_DET_TOL = 1'b0;
  // Byte address of the tolerance register on the register port.
  localparam logic [1:0] ADDR_DET_TOL = 2'(4 * CFG_DET_TOL);

  typedef logic signed [DW-1:0] entry_t;

  // Per-lane square root state carried through the cell chain.
  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0] rad;
  } lane_t;

  // Item side data travelling along with the lanes.
  typedef struct packed {
    logic valid_res;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } side_t;
endpackage

// ===== rtl/rmq_if.sv =====
// Valid/ready channel interfaces for matrices and quaternions.
// Depends on rmq_pkg.
interface rmq_in_if (input logic clk);
  logic valid;
  logic ready;
  rmq_pkg::entry_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    input ready);
  modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    output ready);
endinterface

interface rmq_out_if (input logic clk);
  logic valid;
  logic ready;
  rmq_pkg::entry_t q_scalar, q_x, q_y, q_z;
  logic valid_res;
  modport source (output valid, q_scalar, q_x, q_y, q_z, valid_res, input ready);
  modport sink (input valid, q_scalar, q_x, q_y, q_z, valid_res, output ready);
endinterface

// ===== rtl/rmq_root_cell.sv =====
// One cell of the square root chain: resolves one root bit on four lanes.
// Depends on rmq_pkg.
module rmq_root_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [4:0] step,
  input  logic in_vld,
  input  rmq_pkg::lane_t [3:0] in_lane,
  input  rmq_pkg::side_t in_side,
  output logic out_vld,
  output rmq_pkg::lane_t [3:0] out_lane,
  output rmq_pkg::side_t out_side
);
  rmq_pkg::lane_t [3:0] lane_next;

  // Restoring square root step: bring down two radicand bits, try 4r+1.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [rmq_pkg::RAD_W-1:0] r2;
      logic [rmq_pkg::RAD_W-1:0] trial;
      r2 = {in_lane[i].rem[rmq_pkg::RAD_W-3:0], in_lane[i].rad[rmq_pkg::RAD_W-1 -: 2]};
      trial = {in_lane[i].root, 2'b01};
      lane_next[i].rad = {in_lane[i].rad[rmq_pkg::RAD_W-3:0], 2'b00};
      if (r2 >= trial) begin
        lane_next[i].rem = r2 - trial;
        lane_next[i].root = {in_lane[i].root[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        lane_next[i].rem = r2;
        lane_next[i].root = {in_lane[i].root[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
    if (en) begin
      out_lane <= lane_next;
      out_side <= in_side;
    end
  end

  // The step index only labels the cell's place in the chain.
  logic unused_step;
  assign unused_step = ^step;
endmodule

// ===== rtl/rmq_front.sv =====
// Front stages: determinant products, tolerance test, radicand setup.
// Depends on rmq_pkg.
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  rmq_pkg::entry_t m11, m12, m13, m21, m22, m23, m31, m32, m33,
  input  logic [15:0] det_tolerance,
  output logic out_vld,
  output rmq_pkg::lane_t [3:0] out_lane,
  output rmq_pkg::side_t out_side
);
  localparam int F = rmq_pkg::FRAC_BITS;
  // Stage 1: cofactors and trace combinations.
  logic v1;
  logic signed [32:0] c1, c2, c3;
  rmq_pkg::entry_t a1, b1, cc1;
  logic signed [18:0] t0, t1, t2, t3;
  logic nx, ny, nz;
  // Stage 2: the three row products.
  logic v2;
  logic signed [49:0] p1, p2, p3;
  logic signed [18:0] s0, s1, s2, s3;
  logic mx, my, mz;
  // Stage 3: determinant and deviation.
  logic v3;
  logic signed [rmq_pkg::DET_W-1:0] det3;
  logic signed [18:0] u0, u1, u2, u3;
  logic kx, ky, kz;
  logic [15:0] tol3;

  logic signed [18:0] one;
  assign one = 19'sd1 <<< F;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld; v2 <= v1; v3 <= v2; out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= 33'(m22 * m33) - 33'(m23 * m32);
      c2 <= 33'(m21 * m33) - 33'(m23 * m31);
      c3 <= 33'(m21 * m32) - 33'(m22 * m31);
      a1 <= m11; b1 <= m12; cc1 <= m13;
      t0 <= one + 19'(m11) + 19'(m22) + 19'(m33);
      t1 <= one + 19'(m11) - 19'(m22) - 19'(m33);
      t2 <= one - 19'(m11) + 19'(m22) - 19'(m33);
      t3 <= one - 19'(m11) - 19'(m22) + 19'(m33);
      nx <= (17'(m23) - 17'(m32)) < 0;
      ny <= (17'(m31) - 17'(m13)) < 0;
      nz <= (17'(m12) - 17'(m21)) < 0;
      // Products of a 16-bit entry and a 33-bit cofactor.
      p1 <= 50'(a1) * 50'(c1);
      p2 <= 50'(b1) * 50'(c2);
      p3 <= 50'(cc1) * 50'(c3);
      s0 <= t0; s1 <= t1; s2 <= t2; s3 <= t3;
      mx <= nx; my <= ny; mz <= nz;
      det3 <= 52'(p1) - 52'(p2) + 52'(p3);
      u0 <= s0; u1 <= s1; u2 <= s2; u3 <= s3;
      kx <= mx; ky <= my; kz <= mz;
      tol3 <= det_tolerance;
    end
  end

  // Tolerance test and radicand load for the root chain.
  logic signed [rmq_pkg::DET_W-1:0] dev;
  logic [rmq_pkg::DET_W-1:0] adev;
  logic ok;
  always_comb begin
    dev = det3 - (52'sd1 <<< (3*F));
    adev = dev[rmq_pkg::DET_W-1] ? 52'(-dev) : 52'(dev);
    ok = !(adev > (52'(tol3) << F));
  end

  function automatic rmq_pkg::lane_t load(input logic signed [18:0] t);
    rmq_pkg::lane_t l;
    l.rem = '0;
    l.root = '0;
    l.rad = (t <= 0) ? '0 : (rmq_pkg::RAD_W'(t[17:0]) << F);
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane[0] <= load(u0);
      out_lane[1] <= load(u1);
      out_lane[2] <= load(u2);
      out_lane[3] <= load(u3);
      out_side.valid_res <= ok;
      out_side.neg_x <= kx;
      out_side.neg_y <= ky;
      out_side.neg_z <= kz;
    end
  end

  `RMQ_ASSERT_NEXT(a_v1, clk, rst, en && in_vld, v1)
  `RMQ_ASSERT_NEXT(a_hold, clk, rst, !en, $stable(v3))
  `RMQ_ASSERT_IMPL(a_tol, clk, rst, tol3 == 16'd0 && ok, det3 == (52'sd1 <<< (3*F)))
endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion converter, top level.
// Matrices enter on the in channel (valid/ready), quaternions leave on
// the out channel. The det_tolerance register sits on an APB port at
// address 0, reset value 64.
// Pipeline: 4 front stages plus one cell per root bit (17) plus one
// output stage, 22 register stages in all.
// Throughput: one word per cycle; the whole pipeline advances together
// and holds when the output word is not taken, so in.ready follows
// out.ready or an empty output register.
// Reset (synchronous, rst high) empties the pipeline and restores the
// tolerance. Invalid matrices give a zero quaternion with valid_res low.
// Each vector part takes its sign from an off-diagonal difference.
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_root_cell.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion (
  input  logic clk,
  input  logic rst,
  rmq_in_if.sink in,
  rmq_out_if.source out,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int N = rmq_pkg::NCELL;
  logic [15:0] det_tolerance;
  logic en;

  // Register port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      det_tolerance <= 16'd64;
    end else if (psel && penable && pwrite && paddr == rmq_pkg::ADDR_DET_TOL) begin
      det_tolerance <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == rmq_pkg::ADDR_DET_TOL) ? {16'd0, det_tolerance} : 32'd0;

  // Whole pipeline moves when the output register can take a word.
  assign en = out.ready || !out.valid;
  assign in.ready = en;

  logic fv;
  rmq_pkg::lane_t [3:0] fl;
  rmq_pkg::side_t fs;
  rmq_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in.valid && in.ready),
    .m11(in.m11), .m12(in.m12), .m13(in.m13), .m21(in.m21), .m22(in.m22),
    .m23(in.m23), .m31(in.m31), .m32(in.m32), .m33(in.m33),
    .det_tolerance(det_tolerance), .out_vld(fv), .out_lane(fl), .out_side(fs)
  );

  logic [N:0] cv;
  rmq_pkg::lane_t [N:0][3:0] cl;
  rmq_pkg::side_t [N:0] cs;
  assign cv[0] = fv;
  assign cl[0] = fl;
  assign cs[0] = fs;

  // Chain of root cells, one root bit each.
  for (genvar j = 0; j < N; j++) begin : g_cell
    rmq_root_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(5'(j)),
      .in_vld(cv[j]), .in_lane(cl[j]), .in_side(cs[j]),
      .out_vld(cv[j+1]), .out_lane(cl[j+1]), .out_side(cs[j+1])
    );
  end

  // Round, saturate, sign and zero invalid results.
  function automatic rmq_pkg::entry_t mag(input logic [rmq_pkg::ROOT_W-1:0] r);
    logic [rmq_pkg::ROOT_W:0] q;
    q = ({1'b0, r} + 1'b1) >> 1;
    return (q > 32767) ? 16'sd32767 : rmq_pkg::entry_t'(q[15:0]);
  endfunction

  rmq_pkg::entry_t m0, m1, m2, m3;
  rmq_pkg::side_t sd;
  always_comb begin
    sd = cs[N];
    m0 = mag(cl[N][0].root);
    m1 = mag(cl[N][1].root);
    m2 = mag(cl[N][2].root);
    m3 = mag(cl[N][3].root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= cv[N];
    end
    if (en) begin
      out.valid_res <= sd.valid_res;
      out.q_scalar <= sd.valid_res ? m0 : 16'sd0;
      out.q_x <= !sd.valid_res ? 16'sd0 : (sd.neg_x ? -m1 : m1);
      out.q_y <= !sd.valid_res ? 16'sd0 : (sd.neg_y ? -m2 : m2);
      out.q_z <= !sd.valid_res ? 16'sd0 : (sd.neg_z ? -m3 : m3);
    end
  end

  `RMQ_ASSERT_NEXT(a_stall, clk, rst, out.valid && !out.ready, out.valid && $stable(out.q_x))
  `RMQ_ASSERT_IMPL(a_inv, clk, rst, out.valid && !out.valid_res, out.q_scalar == 16'sd0)
  `RMQ_ASSERT_IMPL(a_pos, clk, rst, out.valid, !out.q_scalar[15])
endmodule
